/* design/l2vn_pkg.sv */
// shared constants, types and state encodings of the l2 vector normalizer
package l2vn_pkg;

    // vector buffer geometry
    localparam int MAX_LEN     = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);

    // datapath widths
    localparam int DATA_W  = 16;              // q4.12 element
    localparam int SQ_W    = 31;              // square of one element, at most 2^30
    localparam int SUM_W   = 37;              // sum of squares over the buffer
    localparam int QUO_W   = 31;              // x^2 * 2^30 / sum, at most 2^30
    localparam int QCNT_W  = $clog2(QUO_W);
    localparam int ROOT_W  = 32;              // square root working register
    localparam int BIT_W   = QUO_W;           // one-hot test bit of the root search
    localparam int MAG_W   = 15;              // rounded q1.14 magnitude
    localparam int RES_ONE = 16384;           // 1.0 in q1.14

    // top level sequencer
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_START,
        ST_CALC
    } t_state;

    // divide and root unit
    typedef enum logic [2:0] {
        U_IDLE,
        U_SQUARE,
        U_DIV,
        U_SQRT,
        U_DONE
    } t_unit_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mag;
    } t_unit_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } t_unit_rsp;

endpackage

/* design/l2vn_ram.sv */
// generic single write port, single read port ram with registered read
module l2vn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/l2vn_unit.sv */
// per element arithmetic: square, restoring divide by the sum, integer root, rounding
module l2vn_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  l2vn_pkg::t_unit_req      i_req,
    input  logic [l2vn_pkg::SUM_W-1:0] i_sum,
    output l2vn_pkg::t_unit_rsp      o_rsp
);
    import l2vn_pkg::*;

    t_unit_state        r_state;
    t_unit_state        n_state;
    logic [DATA_W-1:0]  r_mag;
    logic               r_lsb;
    logic [SUM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [QCNT_W-1:0]  r_cnt;
    logic [ROOT_W-1:0]  r_root;
    logic [BIT_W-1:0]   r_bit;

    logic [2*DATA_W-1:0] w_sq;
    logic [SUM_W:0]      w_shift;
    logic [SUM_W:0]      w_diff;
    logic                w_ge;
    logic [ROOT_W-1:0]   w_trial;
    logic [ROOT_W-1:0]   w_rad;
    logic [ROOT_W-1:0]   w_rad_diff;
    logic                w_fit;
    logic [MAG_W+1:0]    w_round;

    // square of the magnitude
    assign w_sq = r_mag * r_mag;

    // one quotient bit per cycle, the square's low bit enters on the first step
    assign w_shift = {r_rem, (r_cnt == '0) ? r_lsb : 1'b0};
    assign w_ge    = (w_shift >= {1'b0, i_sum});
    assign w_diff  = w_shift - {1'b0, i_sum};

    // one root bit per cycle, test bits walk down by two
    assign w_trial    = r_root + ROOT_W'(r_bit);
    assign w_rad      = ROOT_W'(r_quo);
    assign w_fit      = (w_rad >= w_trial);
    assign w_rad_diff = w_rad - w_trial;

    // round half away from zero on the magnitude
    assign w_round = {1'b0, r_root[MAG_W:0]} + (MAG_W+2)'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE:   if (i_req.start) n_state = U_SQUARE;
            U_SQUARE: n_state = U_DIV;
            U_DIV:    if (r_cnt == QCNT_W'(QUO_W - 1)) n_state = U_SQRT;
            U_SQRT:   if (r_bit[0]) n_state = U_DONE;
            U_DONE:   if (i_req.start) n_state = U_SQUARE;
            default:  n_state = U_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE, U_DONE: begin
                if (i_req.start) begin
                    r_mag <= i_req.mag;
                end
            end
            U_SQUARE: begin
                r_rem <= SUM_W'(w_sq[SQ_W-1:1]);
                r_lsb <= w_sq[0];
                r_cnt <= '0;
            end
            U_DIV: begin
                r_rem  <= w_ge ? w_diff[SUM_W-1:0] : w_shift[SUM_W-1:0];
                r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                r_cnt  <= r_cnt + QCNT_W'(1);
                r_root <= '0;
                r_bit  <= BIT_W'(1) << (BIT_W - 1);
            end
            U_SQRT: begin
                if (w_fit) begin
                    r_quo  <= w_rad_diff[QUO_W-1:0];
                    r_root <= (r_root >> 1) + ROOT_W'(r_bit);
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    // response
    always_comb begin
        o_rsp.done = (r_state == U_DONE);
        o_rsp.mag  = w_round[MAG_W:1];
    end

endmodule

/* design/l2_vector_normalizer.sv */
// top level of the l2 vector normalizer: load sequencer, element buffer, output register
//
// Input channel: one vector element (signed q4.12) per word on i_element_value,
// with i_is_last_in set on the final element. Words are taken one per cycle
// while o_in_stall is low; the first 64 elements of a vector are buffered and
// their squares summed, later ones are dropped and flag the run as overflowed.
// After the last word o_in_stall stays high while the stored elements are
// emitted in order, each divided by the vector's euclidean norm, as rounded
// signed q1.14 on o_normalized_value; o_is_last_out marks the final word and
// o_overflowed is set on every word of a run that lost elements. A zero sum
// gives zero outputs.
// Each output word passes through buffer read, unit start, squaring, a 31 step
// restoring divide, a 16 step integer root and a done state; a zero sum skips
// the unit and goes straight from the unit start to the output register.
// The result sits in an output register; a stall from the receiver holds it
// and halts the next element after its arithmetic finishes. Once the final
// word is loaded the block takes the next vector at once.
// Reset (synchronous, active low) empties the run state and output register;
// the buffer needs no clearing.
module l2_vector_normalizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [l2vn_pkg::DATA_W-1:0] i_element_value,
    input  logic                        i_is_last_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [l2vn_pkg::DATA_W-1:0] o_normalized_value,
    output logic                        o_is_last_out,
    output logic                        o_overflowed
);
    import l2vn_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic                r_drop;
    logic [ADDR_W-1:0]   r_idx;
    logic                r_neg;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_value;
    logic                r_out_last;
    logic                r_out_ovf;

    logic                w_in_acc;
    logic                w_store;
    logic [2*DATA_W-1:0] w_prod;
    logic [DATA_W-1:0]   w_rd_data;
    logic [DATA_W-1:0]   w_rd_mag;
    logic                w_sum_zero;
    logic                w_out_free;
    logic                w_idx_last;
    logic                w_rd_en;
    logic                w_load_out;
    logic [DATA_W-1:0]   w_res_value;
    t_unit_req           w_req;
    t_unit_rsp           w_rsp;

    // input handshake and buffer admission
    assign o_in_stall = (r_state != ST_LOAD);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_store    = w_in_acc && (r_count < CNT_W'(MAX_LEN));
    assign w_prod     = $signed(i_element_value) * $signed(i_element_value);

    assign w_sum_zero = (r_sum == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_idx_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign w_rd_mag   = w_rd_data[DATA_W-1] ? (~w_rd_data + DATA_W'(1)) : w_rd_data;

    // element buffer
    l2vn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_element_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    // divide and root unit
    l2vn_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_sum   (r_sum),
        .o_rsp   (w_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (w_in_acc && i_is_last_in) n_state = ST_READ;
            ST_READ:  n_state = ST_START;
            ST_START: n_state = ST_CALC;
            ST_CALC: begin
                if (w_load_out) begin
                    n_state = w_idx_last ? ST_LOAD : ST_READ;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_rd_en    = 1'b0;
        w_req      = '0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_READ:  w_rd_en = 1'b1;
            ST_START: begin
                w_req.start = !w_sum_zero;
                w_req.mag   = w_rd_mag;
            end
            ST_CALC:  w_load_out = (w_sum_zero || w_rsp.done) && w_out_free;
            default: begin
            end
        endcase
    end

    // signed result
    always_comb begin
        if (w_sum_zero) begin
            w_res_value = '0;
        end else if (r_neg) begin
            w_res_value = DATA_W'(0) - DATA_W'(w_rsp.mag);
        end else begin
            w_res_value = DATA_W'(w_rsp.mag);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_sum       <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_store) begin
                r_sum   <= r_sum + SUM_W'(w_prod[SQ_W-1:0]);
                r_count <= r_count + CNT_W'(1);
            end else if (w_in_acc) begin
                r_drop <= 1'b1;
            end
            if (w_in_acc && i_is_last_in) begin
                r_idx <= '0;
            end
            if (w_load_out) begin
                r_idx <= r_idx + ADDR_W'(1);
                if (w_idx_last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_START) begin
            r_neg <= w_rd_data[DATA_W-1];
        end
        if (w_load_out) begin
            r_out_value <= w_res_value;
            r_out_last  <= w_idx_last;
            r_out_ovf   <= r_drop;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_normalized_value = r_out_value;
    assign o_is_last_out      = r_out_last;
    assign o_overflowed       = r_out_ovf;

    // fill count never passes the buffer size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("element count beyond buffer size");

    // elements are only dropped once the buffer is full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_count == CNT_W'(MAX_LEN)))
        else $error("drop flag set with free buffer entries");

    // a last word starts emission and closes the input side
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_is_last_in) |=> o_in_stall)
        else $error("input open right after last word");

    // normalized words stay within plus or minus one
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_normalized_value) <= $signed(DATA_W'(RES_ONE))
                      && $signed(o_normalized_value) >= -$signed(DATA_W'(RES_ONE))))
        else $error("normalized word out of range");

endmodule

/* tb/testbench.sv */
// self-checking testbench of the l2 vector normalizer with a word-level scoreboard

// one expected output word
typedef struct {
    logic [15:0] value;
    logic        last;
    logic        ovf;
} t_norm_word;

// mirrors the buffer and square sum of the block and queues the words it will emit
class norm_board;
    logic [15:0] held[$];
    logic [36:0] square_total;
    logic        lost;
    t_norm_word  awaited[$];
    int          errors;

    function new();
        square_total = '0;
        lost         = 1'b0;
        errors       = 0;
    endfunction

    // x * 2^14 / sqrt(sum), magnitude rounded half away from zero
    function logic [15:0] scaled(logic signed [15:0] x);
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] trial;
        logic [31:0] root;
        logic [15:0] q;
        int          k;
        if (square_total == 0) return 16'd0;
        mag  = (x < 0) ? 64'(-32'(x)) : 64'(32'(x));
        quo  = ((mag * mag) << 30) / 64'(square_total);
        // floor of the square root, one bit at a time from the top
        root = '0;
        for (k = 31; k >= 0; k--) begin
            trial = 64'(root | (32'd1 << k));
            if (trial * trial <= quo) root = root | (32'd1 << k);
        end
        q = 16'((64'(root) + 64'd1) >> 1);
        return (x < 0) ? -q : q;
    endfunction

    // accepted input word: store and sum, emit the whole vector on the last mark
    function void note_word(logic [15:0] value, logic last);
        t_norm_word w;
        if (held.size() < l2vn_pkg::MAX_LEN) begin
            held.insert(held.size(), value);
            square_total += 37'(longint'($signed(value)) * longint'($signed(value)));
        end else begin
            lost = 1'b1;
        end
        if (last) begin
            foreach (held[i]) begin
                w.value = scaled(held[i]);
                w.last  = (i == held.size() - 1);
                w.ovf   = lost;
                awaited.insert(awaited.size(), w);
            end
            held.delete();
            square_total = '0;
            lost         = 1'b0;
        end
    endfunction

    // accepted output word against the oldest expectation
    function void check_word(logic [15:0] value, logic last, logic ovf);
        t_norm_word w;
        if (awaited.size() == 0) begin
            $error("output word with nothing expected: normalized_value %0d", $signed(value));
            errors++;
            return;
        end
        w = awaited.pop_front();
        if (value !== w.value) begin
            $error("normalized_value: expected %0d, got %0d", $signed(w.value), $signed(value));
            errors++;
        end
        if (last !== w.last) begin
            $error("is_last_out: expected %0b, got %0b", w.last, last);
            errors++;
        end
        if (ovf !== w.ovf) begin
            $error("overflowed: expected %0b, got %0b", w.ovf, ovf);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 480;
    localparam int QUIET_FROM   = 420;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 120;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [15:0] i_element_value = '0;
    logic        i_is_last_in    = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_normalized_value;
    logic        o_is_last_out;
    logic        o_overflowed;

    norm_board   board = new();
    int unsigned items_sent  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left  = 0;
    bit          send_gaps   = 1'b1;
    bit          recv_gaps   = 1'b1;
    bit          quiet       = 1'b0;

    l2_vector_normalizer uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_element_value    (i_element_value),
        .i_is_last_in       (i_is_last_in),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_normalized_value (o_normalized_value),
        .o_is_last_out      (o_is_last_out),
        .o_overflowed       (o_overflowed)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // receiver stall in short bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (recv_gaps && !quiet && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // sample both channels, score and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_word(i_element_value, i_is_last_in);
            if (o_out_valid && !i_out_stall)
                board.check_word(o_normalized_value, o_is_last_out, o_overflowed);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // element value in one of several flavors
    function automatic logic [15:0] pick_element(int unsigned flavor);
        case (flavor)
            6, 7: return 16'(int'($urandom_range(0, 63)) - 32);
            8: begin
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0001;
                    3: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            9: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input word, entered and left at a falling edge
    task automatic send_word(input logic [15:0] value, input logic last);
        if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= value;
        i_is_last_in    <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        quiet = (items_sent >= QUIET_FROM);
        @(negedge i_clk);
    endtask

    // one vector of random elements, last mark on the final word
    task automatic send_vector(input int unsigned len, input int unsigned flavor);
        for (int unsigned i = 0; i < len; i++) send_word(pick_element(flavor), i == len - 1);
    endtask

    // stimulus
    initial begin
        int unsigned len;
        int unsigned pick;
        int unsigned vec_idx;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single element at the positive and negative extremes
        send_word(16'h7FFF, 1'b1);
        send_word(16'h8000, 1'b1);
        // zero sum, single and multi element
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);
        // 3-4-5 triangle
        send_word(16'h3000, 1'b0);
        send_word(16'h4000, 1'b1);
        // extremes next to the smallest step
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b1);
        // alternating signs of equal size
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b1);
        // alternating bit patterns
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);

        // random vectors, first one past the buffer and a full one next
        vec_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (vec_idx == 0)      len = $urandom_range(65, 72);
            else if (vec_idx == 1) len = 64;
            else if (pick < 60)    len = $urandom_range(1, 8);
            else if (pick < 80)    len = $urandom_range(9, 30);
            else if (pick < 88)    len = $urandom_range(60, 64);
            else if (pick < 94)    len = 64;
            else                   len = $urandom_range(65, 72);
            send_vector(len, $urandom_range(0, 9));
            vec_idx++;
        end
        i_in_valid <= 1'b0;

        // drain
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
design/l2vn_pkg.sv
design/l2vn_ram.sv
design/l2vn_unit.sv
design/l2_vector_normalizer.sv
tb/testbench.sv
